### sv/owm_pkg.sv
// ---------------------------------------------------------------------------
// owm_pkg: shared types and constants for the 1-Wire bus master
// Request and drive codes, sequencer phases, the per-transaction result
// record and the CRC-8 bit update.
// ---------------------------------------------------------------------------
package owm_pkg;

  localparam int unsigned TICK_W = 10;

  // Request codes carried by req_type
  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_RESET = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_READ  = 2'd3
  } req_t;

  // Line drive codes
  typedef enum logic [1:0] {
    DRV_HIGH = 2'd0,
    DRV_LOW  = 2'd1,
    DRV_REL  = 2'd2
  } drive_t;

  // Sequencer phases, one-hot
  typedef enum logic [8:0] {
    PH_IDLE     = 9'b000000001,
    PH_RST_LOW  = 9'b000000010,
    PH_RST_WAIT = 9'b000000100,
    PH_RST_TAIL = 9'b000001000,
    PH_WR_LOW   = 9'b000010000,
    PH_WR_REST  = 9'b000100000,
    PH_RD_LOW   = 9'b001000000,
    PH_RD_WAIT  = 9'b010000000,
    PH_RD_REST  = 9'b100000000
  } phase_t;

  // Fixed slot timings in microseconds
  localparam logic [TICK_W-1:0] WRITE1_REST_US = 10'd64;
  localparam logic [TICK_W-1:0] WRITE0_REST_US = 10'd10;
  localparam logic [TICK_W-1:0] READ_LOW_US    = 10'd1;
  localparam logic [TICK_W-1:0] READ_REST_US   = 10'd60;

  localparam logic [7:0] CRC_POLY = 8'h8C;
  localparam logic [2:0] LAST_BIT = 3'd7;

  // One result transaction
  typedef struct packed {
    logic [1:0] line_drive;
    logic       busy_res;
    logic       op_done;
    logic       device_present;
    logic [7:0] rx_byte;
    logic [7:0] crc_value;
    logic       rejected;
  } res_t;

  // Dallas/Maxim CRC-8, one received bit, reflected form
  function automatic logic [7:0] crc8_bit(input logic [7:0] crc, input logic b);
    logic fb;
    fb = crc[0] ^ b;
    return (crc >> 1) ^ (fb ? CRC_POLY : 8'h00);
  endfunction

endpackage

### sv/owm_seq.sv
// ---------------------------------------------------------------------------
// owm_seq: 1-Wire slot sequencer
// Holds the bus state and advances it by one tick or command per accepted
// transaction, producing the result record for that transaction.
// ---------------------------------------------------------------------------
module owm_seq #(
  parameter int unsigned RESET_LOW_US        = 480,
  parameter int unsigned PRESENCE_WAIT_US    = 70,
  parameter int unsigned RESET_TAIL_US       = 450,
  parameter int unsigned WRITE1_LOW_US       = 6,
  parameter int unsigned WRITE0_LOW_US       = 60,
  parameter int unsigned READ_SAMPLE_WAIT_US = 3
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic [1:0]    req_type,
  input  logic [7:0]    tx_byte,
  input  logic          line_level,
  output owm_pkg::res_t res
);

  localparam logic [owm_pkg::TICK_W-1:0] RST_LOW_LEN  = owm_pkg::TICK_W'(RESET_LOW_US);
  localparam logic [owm_pkg::TICK_W-1:0] RST_WAIT_LEN = owm_pkg::TICK_W'(PRESENCE_WAIT_US);
  localparam logic [owm_pkg::TICK_W-1:0] RST_TAIL_LEN = owm_pkg::TICK_W'(RESET_TAIL_US);
  localparam logic [owm_pkg::TICK_W-1:0] WR1_LOW_LEN  = owm_pkg::TICK_W'(WRITE1_LOW_US);
  localparam logic [owm_pkg::TICK_W-1:0] WR0_LOW_LEN  = owm_pkg::TICK_W'(WRITE0_LOW_US);
  localparam logic [owm_pkg::TICK_W-1:0] RD_WAIT_LEN  = owm_pkg::TICK_W'(READ_SAMPLE_WAIT_US);

  owm_pkg::phase_t             phase, phase_next;
  logic [owm_pkg::TICK_W-1:0]  tick_count, tick_count_next, count_inc, len;
  logic [2:0]                  bit_index, bit_index_next;
  logic [7:0]                  shift_data, shift_data_next;
  logic [7:0]                  crc_reg, crc_reg_next;
  logic                        presence_flag, presence_flag_next;
  owm_pkg::drive_t             drive_mode, drive_mode_next;
  logic [7:0]                  rx_last, rx_last_next;
  logic                        done, rej;

  // Length of the current phase
  always_comb begin
    case (phase)
      owm_pkg::PH_RST_LOW:  len = RST_LOW_LEN;
      owm_pkg::PH_RST_WAIT: len = RST_WAIT_LEN;
      owm_pkg::PH_RST_TAIL: len = RST_TAIL_LEN;
      owm_pkg::PH_WR_LOW:   len = shift_data[0] ? WR1_LOW_LEN : WR0_LOW_LEN;
      owm_pkg::PH_WR_REST:  len = shift_data[0] ? owm_pkg::WRITE1_REST_US
                                                : owm_pkg::WRITE0_REST_US;
      owm_pkg::PH_RD_LOW:   len = owm_pkg::READ_LOW_US;
      owm_pkg::PH_RD_WAIT:  len = RD_WAIT_LEN;
      default:              len = owm_pkg::READ_REST_US;
    endcase
  end

  assign count_inc = tick_count + 1'b1;

  // Next state for one transaction
  always_comb begin
    phase_next         = phase;
    tick_count_next    = tick_count;
    bit_index_next     = bit_index;
    shift_data_next    = shift_data;
    crc_reg_next       = crc_reg;
    presence_flag_next = presence_flag;
    drive_mode_next    = drive_mode;
    rx_last_next       = rx_last;
    done               = 1'b0;
    rej                = 1'b0;

    if (owm_pkg::req_t'(req_type) != owm_pkg::REQ_TICK) begin
      // start command: no time passes
      if (phase != owm_pkg::PH_IDLE) begin
        rej = 1'b1;
      end else begin
        tick_count_next = '0;
        drive_mode_next = owm_pkg::DRV_LOW;
        case (owm_pkg::req_t'(req_type))
          owm_pkg::REQ_RESET: begin
            crc_reg_next = '0;
            phase_next   = owm_pkg::PH_RST_LOW;
          end
          owm_pkg::REQ_WRITE: begin
            shift_data_next = tx_byte;
            bit_index_next  = '0;
            phase_next      = owm_pkg::PH_WR_LOW;
          end
          default: begin
            shift_data_next = '0;
            bit_index_next  = '0;
            phase_next      = owm_pkg::PH_RD_LOW;
          end
        endcase
      end
    end else if (phase != owm_pkg::PH_IDLE) begin
      // one microsecond tick
      tick_count_next = count_inc;
      if (count_inc >= len) begin
        tick_count_next = '0;
        case (phase)
          owm_pkg::PH_RST_LOW: begin
            phase_next      = owm_pkg::PH_RST_WAIT;
            drive_mode_next = owm_pkg::DRV_REL;
          end
          owm_pkg::PH_RST_WAIT: begin
            presence_flag_next = ~line_level;
            phase_next         = owm_pkg::PH_RST_TAIL;
            drive_mode_next    = owm_pkg::DRV_REL;
          end
          owm_pkg::PH_RST_TAIL: begin
            phase_next      = owm_pkg::PH_IDLE;
            drive_mode_next = owm_pkg::DRV_HIGH;
            done            = 1'b1;
          end
          owm_pkg::PH_WR_LOW: begin
            phase_next      = owm_pkg::PH_WR_REST;
            drive_mode_next = owm_pkg::DRV_HIGH;
          end
          owm_pkg::PH_WR_REST: begin
            shift_data_next = shift_data >> 1;
            if (bit_index >= owm_pkg::LAST_BIT) begin
              bit_index_next  = '0;
              phase_next      = owm_pkg::PH_IDLE;
              drive_mode_next = owm_pkg::DRV_HIGH;
              done            = 1'b1;
            end else begin
              bit_index_next  = bit_index + 1'b1;
              phase_next      = owm_pkg::PH_WR_LOW;
              drive_mode_next = owm_pkg::DRV_LOW;
            end
          end
          owm_pkg::PH_RD_LOW: begin
            phase_next      = owm_pkg::PH_RD_WAIT;
            drive_mode_next = owm_pkg::DRV_REL;
          end
          owm_pkg::PH_RD_WAIT: begin
            shift_data_next = {line_level, shift_data[7:1]};
            crc_reg_next    = owm_pkg::crc8_bit(crc_reg, line_level);
            phase_next      = owm_pkg::PH_RD_REST;
            drive_mode_next = owm_pkg::DRV_REL;
          end
          default: begin
            if (bit_index >= owm_pkg::LAST_BIT) begin
              bit_index_next  = '0;
              rx_last_next    = shift_data;
              phase_next      = owm_pkg::PH_IDLE;
              drive_mode_next = owm_pkg::DRV_HIGH;
              done            = 1'b1;
            end else begin
              bit_index_next  = bit_index + 1'b1;
              phase_next      = owm_pkg::PH_RD_LOW;
              drive_mode_next = owm_pkg::DRV_LOW;
            end
          end
        endcase
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= owm_pkg::PH_IDLE;
      tick_count    <= '0;
      bit_index     <= '0;
      shift_data    <= '0;
      crc_reg       <= '0;
      presence_flag <= 1'b0;
      drive_mode    <= owm_pkg::DRV_REL;
      rx_last       <= '0;
    end else if (step) begin
      phase         <= phase_next;
      tick_count    <= tick_count_next;
      bit_index     <= bit_index_next;
      shift_data    <= shift_data_next;
      crc_reg       <= crc_reg_next;
      presence_flag <= presence_flag_next;
      drive_mode    <= drive_mode_next;
      rx_last       <= rx_last_next;
    end
  end

  // Result record reflects the state after this transaction
  always_comb begin
    res.line_drive     = drive_mode_next;
    res.busy_res       = (phase_next != owm_pkg::PH_IDLE);
    res.op_done        = done;
    res.device_present = presence_flag_next;
    res.rx_byte        = rx_last_next;
    res.crc_value      = crc_reg_next;
    res.rejected       = rej;
  end

`ifndef NO_ASSERTIONS
  // A completing tick leaves the bus idle and strongly pulled high
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    step && done |-> !res.busy_res && res.line_drive == owm_pkg::DRV_HIGH)
    else $error("op_done without returning to idle");

  // A rejected command leaves the state untouched
  a_rej_hold: assert property (@(posedge clk) disable iff (rst)
    step && rej |=> $stable(phase) && $stable(tick_count) && $stable(shift_data))
    else $error("rejected command disturbed the sequencer");

  // Completion and rejection never coincide
  a_done_rej: assert property (@(posedge clk) disable iff (rst)
    step |-> !(done && rej))
    else $error("done and rejected in one transaction");

  // The tick counter stays below the length of the current phase
  a_count_rng: assert property (@(posedge clk) disable iff (rst)
    phase != owm_pkg::PH_IDLE |-> tick_count < len || len == '0)
    else $error("tick counter overran its phase");
`endif

endmodule

### sv/owm_skid.sv
// ---------------------------------------------------------------------------
// owm_skid: result output register with skid stage
// Holds finished result transactions so the input side keeps accepting
// while the consumer stalls.
// ---------------------------------------------------------------------------
module owm_skid (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  owm_pkg::res_t push_data,
  output logic          full,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output owm_pkg::res_t rsp_data
);

  logic          skid_valid;
  owm_pkg::res_t skid_data;
  logic          take;

  assign take = rsp_valid && !rsp_stall;
  assign full = skid_valid;

  // Valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (push) begin
      if (!rsp_valid || take) begin
        rsp_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (push) begin
      if (!rsp_valid || take) begin
        rsp_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end else if (take && skid_valid) begin
      rsp_data <= skid_data;
    end
  end

endmodule

### sv/one_wire_bus_master_core.sv
// ---------------------------------------------------------------------------
// one_wire_bus_master_core: 1-Wire bus master stepped by 1 us ticks
// Takes tick and start-command transactions and returns one result
// transaction for each.
// ---------------------------------------------------------------------------
// Each request transaction is a 1 us tick carrying the sampled line level,
// or a command to start a reset/presence cycle, a byte write or a byte read
// (bytes LSB first). Every request yields exactly one result transaction
// with the line drive, busy, done, presence, last read byte, the CRC-8 of
// bits read since the last reset, and a rejected flag for commands issued
// while busy. One request is taken per clock cycle while req_stall is low;
// the sequencer updates its state as the request is accepted and the result
// is registered in a two-entry output buffer, which lets requests continue
// while the consumer stalls; req_stall rises only once both entries are full.
module one_wire_bus_master_core #(
  parameter int unsigned RESET_LOW_US        = 480,
  parameter int unsigned PRESENCE_WAIT_US    = 70,
  parameter int unsigned RESET_TAIL_US       = 450,
  parameter int unsigned WRITE1_LOW_US       = 6,
  parameter int unsigned WRITE0_LOW_US       = 60,
  parameter int unsigned READ_SAMPLE_WAIT_US = 3
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic [1:0] req_type,
  input  logic [7:0] tx_byte,
  input  logic       line_level,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output logic [1:0] line_drive,
  output logic       busy_res,
  output logic       op_done,
  output logic       device_present,
  output logic [7:0] rx_byte,
  output logic [7:0] crc_value,
  output logic       rejected
);

  logic          step;
  logic          full;
  owm_pkg::res_t res, rsp_data;

  assign req_stall = full;
  assign step      = req_valid && !full;

  // Slot sequencer
  owm_seq #(
    .RESET_LOW_US        (RESET_LOW_US),
    .PRESENCE_WAIT_US    (PRESENCE_WAIT_US),
    .RESET_TAIL_US       (RESET_TAIL_US),
    .WRITE1_LOW_US       (WRITE1_LOW_US),
    .WRITE0_LOW_US       (WRITE0_LOW_US),
    .READ_SAMPLE_WAIT_US (READ_SAMPLE_WAIT_US)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .req_type   (req_type),
    .tx_byte    (tx_byte),
    .line_level (line_level),
    .res        (res)
  );

  // Result buffer
  owm_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (step),
    .push_data (res),
    .full      (full),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

  assign line_drive     = rsp_data.line_drive;
  assign busy_res       = rsp_data.busy_res;
  assign op_done        = rsp_data.op_done;
  assign device_present = rsp_data.device_present;
  assign rx_byte        = rsp_data.rx_byte;
  assign crc_value      = rsp_data.crc_value;
  assign rejected       = rsp_data.rejected;

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the 1-Wire bus master core
// A short table of directed requests (idle ticks, commands while busy)
// followed by random reset, write and read cycles fed with microsecond ticks
// and random line levels. Every result transaction is checked field by field
// against a cycle-free model of the slot sequencer kept in the bench.
// ---------------------------------------------------------------------------
module tb_top;

  // Slot timings, shared by the instance and the bench model
  localparam int unsigned RESET_LOW_US        = 480;
  localparam int unsigned PRESENCE_WAIT_US    = 70;
  localparam int unsigned RESET_TAIL_US       = 450;
  localparam int unsigned WRITE1_LOW_US       = 6;
  localparam int unsigned WRITE0_LOW_US       = 60;
  localparam int unsigned READ_SAMPLE_WAIT_US = 3;

  localparam int RANDOM_ITEMS = 940;
  localparam int STUCK_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 8;

  // Results that can be read straight off the spec
  localparam owm_pkg::res_t IDLE_ST =
    '{owm_pkg::DRV_REL, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0};
  localparam owm_pkg::res_t BUSY_ST =
    '{owm_pkg::DRV_LOW, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0};
  localparam owm_pkg::res_t REJ_ST  =
    '{owm_pkg::DRV_LOW, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 1'b1};
  localparam owm_pkg::res_t NO_ST   = '0;

  typedef struct packed {
    owm_pkg::req_t r;
    logic [7:0]    tx;
    logic          lvl;
    logic          typed;
    owm_pkg::res_t want;
  } probe_t;

  logic          clk = 1'b0;
  logic          rst;
  logic          req_valid;
  logic          req_stall;
  owm_pkg::req_t req_type;
  logic [7:0]    tx_byte;
  logic          line_level;
  logic          rsp_valid;
  logic          rsp_stall;
  logic [1:0]    line_drive;
  logic          busy_res;
  logic          op_done;
  logic          device_present;
  logic [7:0]    rx_byte;
  logic [7:0]    crc_value;
  logic          rejected;

  // Bench copy of the sequencer state
  owm_pkg::phase_t seq_phase;
  logic [9:0]      us_count;
  logic [2:0]      bit_pos;
  logic [7:0]      shift_reg;
  logic [7:0]      crc_acc;
  logic            present_q;
  owm_pkg::drive_t drive_q;
  logic [7:0]      rx_hold;
  owm_pkg::req_t   op_kind;

  owm_pkg::res_t line_status_due[$];
  int   ops_completed[4];
  int   requests_sent;
  int   results_checked;
  int   rejects_seen;
  int   presence_hits;
  int   mismatches;
  int   stuck_cycles;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  one_wire_bus_master_core #(
    .RESET_LOW_US       (RESET_LOW_US),
    .PRESENCE_WAIT_US   (PRESENCE_WAIT_US),
    .RESET_TAIL_US      (RESET_TAIL_US),
    .WRITE1_LOW_US      (WRITE1_LOW_US),
    .WRITE0_LOW_US      (WRITE0_LOW_US),
    .READ_SAMPLE_WAIT_US(READ_SAMPLE_WAIT_US)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .req_type      (req_type),
    .tx_byte       (tx_byte),
    .line_level    (line_level),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .line_drive    (line_drive),
    .busy_res      (busy_res),
    .op_done       (op_done),
    .device_present(device_present),
    .rx_byte       (rx_byte),
    .crc_value     (crc_value),
    .rejected      (rejected)
  );

  // Dallas/Maxim CRC-8, one bit, reflected
  function automatic logic [7:0] crc8_maxim_next(input logic [7:0] c, input logic b);
    logic [7:0] nxt;
    nxt = {1'b0, c[7:1]};
    if (c[0] != b) nxt = nxt ^ owm_pkg::CRC_POLY;
    return nxt;
  endfunction

  // Length of the current slot phase in microseconds
  function automatic int unsigned slot_us(input owm_pkg::phase_t ph, input logic lsb);
    case (ph)
      owm_pkg::PH_RST_LOW:  return RESET_LOW_US;
      owm_pkg::PH_RST_WAIT: return PRESENCE_WAIT_US;
      owm_pkg::PH_RST_TAIL: return RESET_TAIL_US;
      owm_pkg::PH_WR_LOW:   return lsb ? WRITE1_LOW_US : WRITE0_LOW_US;
      owm_pkg::PH_WR_REST:  return lsb ? owm_pkg::WRITE1_REST_US : owm_pkg::WRITE0_REST_US;
      owm_pkg::PH_RD_LOW:   return owm_pkg::READ_LOW_US;
      owm_pkg::PH_RD_WAIT:  return READ_SAMPLE_WAIT_US;
      default:              return owm_pkg::READ_REST_US;
    endcase
  endfunction

  // Advance the bench sequencer by one request and give the result it yields
  task automatic advance_line_sequencer(input owm_pkg::req_t r, input logic [7:0] tx,
                                        input logic lvl, output owm_pkg::res_t res);
    logic done_now;
    logic rej_now;
    done_now = 1'b0;
    rej_now  = 1'b0;
    if (r != owm_pkg::REQ_TICK) begin
      if (seq_phase != owm_pkg::PH_IDLE) begin
        rej_now = 1'b1;
        rejects_seen++;
      end else begin
        op_kind  = r;
        drive_q  = owm_pkg::DRV_LOW;
        us_count = '0;
        bit_pos  = '0;
        case (r)
          owm_pkg::REQ_RESET: begin
            crc_acc   = '0;
            seq_phase = owm_pkg::PH_RST_LOW;
          end
          owm_pkg::REQ_WRITE: begin
            shift_reg = tx;
            seq_phase = owm_pkg::PH_WR_LOW;
          end
          default: begin
            shift_reg = '0;
            seq_phase = owm_pkg::PH_RD_LOW;
          end
        endcase
      end
    end else if (seq_phase != owm_pkg::PH_IDLE) begin
      us_count = us_count + 10'd1;
      if (us_count >= slot_us(seq_phase, shift_reg[0])) begin
        us_count = '0;
        case (seq_phase)
          owm_pkg::PH_RST_LOW: begin
            seq_phase = owm_pkg::PH_RST_WAIT;
            drive_q   = owm_pkg::DRV_REL;
          end
          owm_pkg::PH_RST_WAIT: begin
            present_q = ~lvl;
            if (!lvl) presence_hits++;
            seq_phase = owm_pkg::PH_RST_TAIL;
            drive_q   = owm_pkg::DRV_REL;
          end
          owm_pkg::PH_RST_TAIL: begin
            seq_phase = owm_pkg::PH_IDLE;
            drive_q   = owm_pkg::DRV_HIGH;
            done_now  = 1'b1;
          end
          owm_pkg::PH_WR_LOW: begin
            seq_phase = owm_pkg::PH_WR_REST;
            drive_q   = owm_pkg::DRV_HIGH;
          end
          owm_pkg::PH_WR_REST: begin
            shift_reg = shift_reg >> 1;
            if (bit_pos == owm_pkg::LAST_BIT) begin
              bit_pos   = '0;
              seq_phase = owm_pkg::PH_IDLE;
              drive_q   = owm_pkg::DRV_HIGH;
              done_now  = 1'b1;
            end else begin
              bit_pos   = bit_pos + 3'd1;
              seq_phase = owm_pkg::PH_WR_LOW;
              drive_q   = owm_pkg::DRV_LOW;
            end
          end
          owm_pkg::PH_RD_LOW: begin
            seq_phase = owm_pkg::PH_RD_WAIT;
            drive_q   = owm_pkg::DRV_REL;
          end
          owm_pkg::PH_RD_WAIT: begin
            shift_reg = {lvl, shift_reg[7:1]};
            crc_acc   = crc8_maxim_next(crc_acc, lvl);
            seq_phase = owm_pkg::PH_RD_REST;
            drive_q   = owm_pkg::DRV_REL;
          end
          default: begin
            if (bit_pos == owm_pkg::LAST_BIT) begin
              bit_pos   = '0;
              rx_hold   = shift_reg;
              seq_phase = owm_pkg::PH_IDLE;
              drive_q   = owm_pkg::DRV_HIGH;
              done_now  = 1'b1;
            end else begin
              bit_pos   = bit_pos + 3'd1;
              seq_phase = owm_pkg::PH_RD_LOW;
              drive_q   = owm_pkg::DRV_LOW;
            end
          end
        endcase
        if (done_now) ops_completed[op_kind]++;
      end
    end
    res = '{drive_q, seq_phase != owm_pkg::PH_IDLE, done_now, present_q, rx_hold,
            crc_acc, rej_now};
  endtask

  // One line per mismatch, and a count
  task automatic log_mismatch(input string msg);
    $display("[%0t] MISMATCH result %0d: %s", $realtime, results_checked, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input int got, input int want);
    if (got != want) log_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  // Offer one request transaction, wait for it to be taken, then predict
  task automatic offer_request(input owm_pkg::req_t r, input logic [7:0] tx,
                               input logic lvl, input bit steady,
                               output owm_pkg::res_t pred);
    if (!steady) begin
      while ($urandom_range(99) < 27) begin
        req_valid <= 1'b0;
        @(posedge clk);
      end
    end
    req_valid  <= 1'b1;
    req_type   <= r;
    tx_byte    <= tx;
    line_level <= lvl;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    requests_sent++;
    advance_line_sequencer(r, tx, lvl, pred);
  endtask

  // Sender: directed table, then random slot traffic
  initial begin
    probe_t        probe_rows [12];
    owm_pkg::res_t pred;
    owm_pkg::req_t r;
    logic [7:0]    tx;
    logic          lvl;
    int            rand_items;
    bit            paused;
    bit            ignored;

    rst        <= 1'b1;
    req_valid  <= 1'b0;
    req_type   <= owm_pkg::REQ_TICK;
    tx_byte    <= 8'h00;
    line_level <= 1'b1;

    seq_phase = owm_pkg::PH_IDLE;
    us_count  = '0;
    bit_pos   = '0;
    shift_reg = '0;
    crc_acc   = '0;
    present_q = 1'b0;
    drive_q   = owm_pkg::DRV_REL;
    rx_hold   = '0;
    op_kind   = owm_pkg::REQ_TICK;
    ops_completed = '{0, 0, 0, 0};

    // Idle ticks, a read start, commands while busy, first read slot ticks
    probe_rows = '{
      '{owm_pkg::REQ_TICK,  8'hFF, 1'b1, 1'b1, IDLE_ST},
      '{owm_pkg::REQ_TICK,  8'h00, 1'b0, 1'b1, IDLE_ST},
      '{owm_pkg::REQ_READ,  8'hA5, 1'b1, 1'b1, BUSY_ST},
      '{owm_pkg::REQ_RESET, 8'h00, 1'b0, 1'b1, REJ_ST},
      '{owm_pkg::REQ_WRITE, 8'hFF, 1'b1, 1'b1, REJ_ST},
      '{owm_pkg::REQ_READ,  8'h00, 1'b0, 1'b1, REJ_ST},
      '{owm_pkg::REQ_TICK,  8'h3C, 1'b1, 1'b0, NO_ST},
      '{owm_pkg::REQ_TICK,  8'hC3, 1'b0, 1'b0, NO_ST},
      '{owm_pkg::REQ_TICK,  8'h00, 1'b1, 1'b0, NO_ST},
      '{owm_pkg::REQ_TICK,  8'hFF, 1'b1, 1'b0, NO_ST},
      '{owm_pkg::REQ_WRITE, 8'h81, 1'b0, 1'b0, NO_ST},
      '{owm_pkg::REQ_TICK,  8'h5A, 1'b0, 1'b0, NO_ST}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (probe_rows[i]) begin
      offer_request(probe_rows[i].r, probe_rows[i].tx, probe_rows[i].lvl, 1'b0, pred);
      line_status_due.push_back(probe_rows[i].typed ? probe_rows[i].want : pred);
    end

    // Random part: finish the open read, then a write, a reset, then mixed
    rand_items = 0;
    paused     = 1'b0;
    while (rand_items < RANDOM_ITEMS) begin
      ignored = 1'b0;
      if (seq_phase != owm_pkg::PH_IDLE) begin
        r = ($urandom_range(99) < 3) ? owm_pkg::req_t'($urandom_range(1, 3))
                                     : owm_pkg::REQ_TICK;
      end else if ($urandom_range(9) == 0) begin
        r       = owm_pkg::REQ_TICK;
        ignored = 1'b1;
      end else if (ops_completed[owm_pkg::REQ_WRITE] == 0) begin
        r = owm_pkg::REQ_WRITE;
      end else if (ops_completed[owm_pkg::REQ_RESET] == 0) begin
        r = owm_pkg::REQ_RESET;
      end else begin
        case ($urandom_range(4))
          0:       r = owm_pkg::REQ_RESET;
          1, 2:    r = owm_pkg::REQ_WRITE;
          default: r = owm_pkg::REQ_READ;
        endcase
      end
      tx  = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 8'hFF : 8'h00)
                                     : 8'($urandom_range(255));
      lvl = 1'($urandom_range(1));

      // Let everything drain once, with the request side quiet
      if (rand_items == 700 && !paused) begin
        paused = 1'b1;
        req_valid <= 1'b0;
        @(posedge clk);
        while (line_status_due.size() != 0) @(posedge clk);
      end

      offer_request(r, tx, lvl, rand_items >= 100 && rand_items < 300, pred);
      line_status_due.push_back(pred);
      if (!ignored) rand_items++;
    end
    req_valid <= 1'b0;

    while (line_status_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests and %0d results: %0d resets, %0d writes, %0d reads done",
             requests_sent, results_checked, ops_completed[owm_pkg::REQ_RESET],
             ops_completed[owm_pkg::REQ_WRITE], ops_completed[owm_pkg::REQ_READ]);
    $display("Busy commands refused: %0d, presence pulses seen: %0d, mismatches: %0d",
             rejects_seen, presence_hits, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Receiver: random stall, one long hold-off, one stretch with no stall
  initial begin
    owm_pkg::res_t got;
    owm_pkg::res_t want;
    int            hold_left;
    bit            held;

    rsp_stall <= 1'b0;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (rsp_valid && !rsp_stall) begin
          got = '{line_drive, busy_res, op_done, device_present, rx_byte, crc_value,
                  rejected};
          if (line_status_due.size() == 0) begin
            log_mismatch("result transaction with nothing expected");
          end else begin
            want = line_status_due.pop_front();
            compare_field("line_drive", got.line_drive, want.line_drive);
            compare_field("busy_res", got.busy_res, want.busy_res);
            compare_field("op_done", got.op_done, want.op_done);
            compare_field("device_present", got.device_present, want.device_present);
            compare_field("rx_byte", got.rx_byte, want.rx_byte);
            compare_field("crc_value", got.crc_value, want.crc_value);
            compare_field("rejected", got.rejected, want.rejected);
          end
          results_checked++;
        end

        if (hold_left > 0) begin
          hold_left--;
          rsp_stall <= 1'b1;
        end else if (results_checked == 60 && !held) begin
          held      = 1'b1;
          hold_left = HOLD_CYCLES - 1;
          rsp_stall <= 1'b1;
        end else if (results_checked >= 400 && results_checked < 600) begin
          rsp_stall <= 1'b0;
        end else begin
          rsp_stall <= ($urandom_range(99) < 27);
        end
      end
    end
  end

  // Watchdog: cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("Timeout after %0d cycles with no transaction", STUCK_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

endmodule
